// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;
  localparam int unsigned KEY_BITS    = 32;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;   // insert transfer, queue not full
    logic pop;   // pop transfer, queue not empty
    logic desc;  // descending order
  } ctrl_t;

  // Stored key s lies strictly after key k in queue order
  function automatic logic key_after(input logic [KEY_BITS-1:0] s,
                                     input logic [KEY_BITS-1:0] k,
                                     input logic desc);
    key_after = desc ? (s < k) : (s > k);
  endfunction

endpackage

// ----- src/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid_i / in_ready_o    opcode, entry_key, entry_id
//  out       output     out_valid_o / out_ready_i  status, head_key, head_id,
//                                                  found, occupancy
//  cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (order_descending)
//
//  All cells compare and shift in parallel, so one item is accepted per
//  clock while the output side does not stall; the result appears on the
//  output register the cycle after the transfer.
//  A new item is taken while the output register is empty or being drained.
//  Reset clears the fill count, the order register and the output valid flag;
//  slot contents are not reset. A stall on the output side holds the input ready low.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH   = DEPTH_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF,
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [KEY_BITS-1:0] entry_key_i,
  input  logic [ID_BITS-1:0]  entry_id_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [KEY_BITS-1:0] head_key_o,
  output logic [ID_BITS-1:0]  head_id_o,
  output logic                found_o,
  output logic [CNT_W-1:0]    occupancy_o,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             desc_q;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [KEY_BITS-1:0] head_key_q, head_key_d;
  logic [ID_BITS-1:0]  head_id_q, head_id_d;
  logic             found_q, found_d;
  logic [CNT_W-1:0] occ_out_q;

  logic    in_fire;
  logic    full, empty;
  opcode_e op;
  ctrl_t   ctrl;

  logic [DEPTH-1:0] occ, go, match;
  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [ID_BITS-1:0]  cell_id  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = opcode_e'(opcode_i);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  // Control broadcast to the cell row
  assign ctrl.ins  = in_fire && (op == OP_INSERT) && !full;
  assign ctrl.pop  = in_fire && (op == OP_POP) && !empty;
  assign ctrl.desc = desc_q;

  // Cell row, slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                go_left;
    logic [KEY_BITS-1:0] left_key, right_key;
    logic [ID_BITS-1:0]  left_id, right_id;

    assign occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign go_left  = 1'b0;
      assign left_key = '0;
      assign left_id  = '0;
    end else begin : g_mid
      assign go_left  = go[i-1];
      assign left_key = cell_key[i-1];
      assign left_id  = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = '0;
      assign right_id  = '0;
    end else begin : g_body
      assign right_key = cell_key[i+1];
      assign right_id  = cell_id[i+1];
    end

    spq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[i]),
      .en_i       (in_fire),
      .new_key_i  (entry_key_i),
      .new_id_i   (entry_id_i),
      .go_left_i  (go_left),
      .left_key_i (left_key),
      .left_id_i  (left_id),
      .right_key_i(right_key),
      .right_id_i (right_id),
      .go_o       (go[i]),
      .match_o    (match[i]),
      .key_o      (cell_key[i]),
      .id_o       (cell_id[i])
    );
  end

  // Result and fill count for the transferred item
  always_comb begin
    count_d    = count_q;
    status_d   = ST_OK;
    head_key_d = '0;
    head_id_d  = '0;
    found_d    = 1'b0;
    case (op)
      OP_INSERT: begin
        if (full) status_d = ST_FULL;
        else      count_d  = count_q + CNT_W'(1);
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          head_key_d = cell_key[0];
          head_id_d  = cell_id[0];
          count_d    = count_q - CNT_W'(1);
        end
      end
      OP_FIND: found_d = |match;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      // order may only change while the queue is empty
      if (cfg_valid_i && empty) begin
        desc_q <= cfg_data_i;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q   <= status_d;
      head_key_q <= head_key_d;
      head_id_q  <= head_id_d;
      found_q    <= found_d;
      occ_out_q  <= count_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign head_key_o  = head_key_q;
  assign head_id_o   = head_id_q;
  assign found_o     = found_q;
  assign occupancy_o = occ_out_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == OP_POP) && !empty) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not decrement fill count");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_EMPTY)) |-> (head_key_q == '0 && occ_out_q == '0))
    else $error("empty pop result carries data");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == OP_INSERT) && full) |=> (count_q == CNT_W'(DEPTH)))
    else $error("insert into full queue changed fill count");

endmodule

// ----- src/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds a key and id, compares against the incoming key and
// shifts with its neighbours on insert and pop.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic                clk_i,
  input  ctrl_t               ctrl_i,
  input  logic                occ_i,      // slot currently holds an entry
  input  logic                en_i,       // an item is transferred this cycle
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [ID_BITS-1:0]  new_id_i,
  // left neighbour (towards the head)
  input  logic                go_left_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [ID_BITS-1:0]  left_id_i,
  // right neighbour (towards the tail)
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [ID_BITS-1:0]  right_id_i,
  output logic                go_o,
  output logic                match_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [ID_BITS-1:0]  id_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [ID_BITS-1:0]  id_q, id_d;

  // Insert point lies here or earlier: free slot, or stored key after new key
  assign go_o = !occ_i || key_after(key_q, new_key_i, ctrl_i.desc);

  // Find hit, only if the scan has not stopped before this slot
  assign match_o = occ_i && (id_q == new_id_i) && !go_left_i;

  // Next slot contents
  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    if (ctrl_i.ins) begin
      if (go_left_i) begin
        key_d = left_key_i;
        id_d  = left_id_i;
      end else if (go_o) begin
        key_d = new_key_i;
        id_d  = new_id_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
      id_d  = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
      id_q  <= id_d;
    end
  end

  assign key_o = key_q;
  assign id_o  = id_q;

endmodule
